@@ hdl/gaussian_blur_rgb_stream_macros.svh @@
// Assertion helpers for the top-level block, which checks itself.
`ifndef GAUSSIAN_BLUR_RGB_STREAM_MACROS_SVH
`define GAUSSIAN_BLUR_RGB_STREAM_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define GBR_AST_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("gbr assertion failed");

// Next-cycle implication, checked outside reset.
`define GBR_AST_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("gbr assertion failed");

`endif

@@ hdl/gbr_pkg.sv @@
`default_nettype none
package gbr_pkg;

    localparam int PIX_W = 24;
    localparam int CH_W  = 8;
    localparam int WGT_W = 9;
    localparam int ROW_W = 13;
    localparam int ACC_W = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 3'd0,
        CFG_FRAME_HEIGHT = 3'd1,
        CFG_KERNEL_RAD   = 3'd2,
        CFG_WEIGHT0      = 3'd3,
        CFG_WEIGHT1      = 3'd4,
        CFG_WEIGHT2      = 3'd5,
        CFG_WEIGHT3      = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [10:0]      frame_width;
        logic [12:0]      frame_height;
        logic [1:0]       kernel_radius;
        logic [WGT_W-1:0] weight0;
        logic [WGT_W-1:0] weight1;
        logic [WGT_W-1:0] weight2;
        logic [WGT_W-1:0] weight3;
    } t_cfg;

    typedef struct packed {
        logic accept;
        logic load;
        logic prep;
        logic tap;
        logic emit;
        logic next_x;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic any;
        logic tap_last;
        logic x_last;
        logic out_free;
    } t_sts;

    function automatic logic [WGT_W-1:0] f_weight(t_cfg cfg, logic [1:0] d);
        logic [WGT_W-1:0] w;
        case (d)
            2'd0:    w = cfg.weight0;
            2'd1:    w = cfg.weight1;
            2'd2:    w = cfg.weight2;
            default: w = cfg.weight3;
        endcase
        return w;
    endfunction

    function automatic logic [CH_W-1:0] f_sat(logic [ACC_W-1:0] acc);
        logic [CH_W-1:0] v;
        if (acc[ACC_W-1:16] > (ACC_W-16)'(255)) begin
            v = 8'hFF;
        end else begin
            v = acc[23:16];
        end
        return v;
    endfunction

endpackage
`default_nettype wire

@@ hdl/gbr_ctrl.sv @@
`default_nettype none
module gbr_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire gbr_pkg::t_sts i_sts,
    output gbr_pkg::t_cmd      o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_LOAD   = 7'b0000010,
        S_PREP   = 7'b0000100,
        S_TAP    = 7'b0001000,
        S_DRAIN  = 7'b0010000,
        S_EMIT   = 7'b0100000,
        S_FINISH = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_state    = S_PREP;
            end
            S_PREP: begin
                if (i_sts.any) begin
                    o_cmd.prep = 1'b1;
                    n_state    = S_TAP;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_TAP: begin
                o_cmd.tap = 1'b1;
                if (i_sts.tap_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.x_last) begin
                        n_state = S_FINISH;
                    end else begin
                        o_cmd.next_x = 1'b1;
                        n_state      = S_PREP;
                    end
                end
            end
            S_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

@@ hdl/gbr_dpath.sv @@
`default_nettype none
module gbr_dpath #(
    parameter int MAX_RADIUS = 3,
    parameter int MAX_WIDTH  = 1024
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire gbr_pkg::t_cfg                i_cfg,
    input  wire gbr_pkg::t_cmd                i_cmd,
    output gbr_pkg::t_sts                     o_sts,
    input  wire logic                         i_opcode,
    input  wire logic [gbr_pkg::PIX_W-1:0]    i_pix,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic [gbr_pkg::PIX_W-1:0]         o_out_pix,
    output logic                              o_out_last,
    output logic                              o_out_eof
);

    localparam int WIN   = 2 * MAX_RADIUS + 1;
    localparam int LINES = 2 * MAX_RADIUS;
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int AW    = $clog2(WIN);
    localparam int PW    = gbr_pkg::PIX_W;
    localparam int AC    = gbr_pkg::ACC_W;

    logic [LINES*PW-1:0] r_mem [MAX_WIDTH];
    logic [LINES*PW-1:0] r_rdata;
    logic [PW-1:0]       r_pix;
    logic [PW-1:0]       r_win [WIN][WIN];
    logic [12:0]         r_row;
    logic [CW-1:0]       r_col;
    logic [11:0]         r_y;
    logic [CW-1:0]       r_x, r_xhi;
    logic [1:0]          r_n;
    logic                r_any, r_rowend, r_wrap;
    logic [2:0]          r_dyi, r_dxi;
    logic                r_pv;
    logic [17:0]         r_wprod;
    logic [PW-1:0]       r_tap;
    logic [AC-1:0]       r_acc [3];
    logic                r_ovalid;

    logic [12:0]         w_lim;
    logic [11:0]         h_m1;
    logic [1:0]          rad;
    logic signed [15:0]  t_s, c_s, rad_s, hm1_s, wm1_s, y_s, lo_s, xlo_s;
    logic                rowend, yvalid, any;
    logic [2:0]          span;
    logic signed [15:0]  dy_s, dx_s, yy_s, xx_s, yc_s, xc_s, a_s, b_s;
    logic [AW-1:0]       a_idx, b_idx;
    logic [2:0]          dy_abs, dx_abs;

    always_comb begin
        if (i_cfg.frame_width == 11'd0) begin
            w_lim = 13'd0;
        end else if ({2'b00, i_cfg.frame_width} > 13'(MAX_WIDTH)) begin
            w_lim = 13'(MAX_WIDTH - 1);
        end else begin
            w_lim = {2'b00, i_cfg.frame_width} - 13'd1;
        end
        if (i_cfg.frame_height == 13'd0) begin
            h_m1 = 12'd0;
        end else if (i_cfg.frame_height > 13'd4096) begin
            h_m1 = 12'd4095;
        end else begin
            h_m1 = 12'(i_cfg.frame_height - 13'd1);
        end
        if (int'(i_cfg.kernel_radius) > MAX_RADIUS) begin
            rad = 2'(MAX_RADIUS);
        end else begin
            rad = i_cfg.kernel_radius;
        end
    end

    assign t_s   = $signed({3'b000, r_row});
    assign c_s   = $signed(16'(r_col));
    assign rad_s = $signed({14'd0, rad});
    assign hm1_s = $signed({4'd0, h_m1});
    assign wm1_s = $signed({3'd0, w_lim});
    assign span  = {rad, 1'b0};

    always_comb begin
        y_s    = t_s - rad_s;
        lo_s   = c_s - rad_s;
        rowend = (c_s >= wm1_s);
        yvalid = !y_s[15] && (y_s <= hm1_s);
        xlo_s  = lo_s;
        if (rowend) begin
            if (lo_s[15]) begin
                xlo_s = '0;
            end
            any = yvalid && (xlo_s <= wm1_s);
        end else begin
            any = yvalid && !lo_s[15];
        end
    end

    always_comb begin
        dy_s = $signed({13'd0, r_dyi}) - rad_s;
        dx_s = $signed({13'd0, r_dxi}) - rad_s;
        yy_s = $signed({4'd0, r_y}) + dy_s;
        xx_s = $signed(16'(r_x)) + dx_s;
        yc_s = yy_s[15] ? 16'sd0 : ((yy_s > hm1_s) ? hm1_s : yy_s);
        xc_s = xx_s[15] ? 16'sd0 : ((xx_s > wm1_s) ? wm1_s : xx_s);
        a_s  = t_s - yc_s;
        b_s  = c_s - xc_s;
        a_idx = a_s[15] ? '0 : ((a_s > 16'(WIN - 1)) ? AW'(WIN - 1) : a_s[AW-1:0]);
        b_idx = b_s[15] ? '0 : ((b_s > 16'(WIN - 1)) ? AW'(WIN - 1) : b_s[AW-1:0]);
        dy_abs = (r_dyi >= {1'b0, rad}) ? r_dyi - {1'b0, rad} : {1'b0, rad} - r_dyi;
        dx_abs = (r_dxi >= {1'b0, rad}) ? r_dxi - {1'b0, rad} : {1'b0, rad} - r_dxi;
    end

    assign o_sts.any      = r_any;
    assign o_sts.tap_last = (r_dyi == span) && (r_dxi == span);
    assign o_sts.x_last   = (r_x == r_xhi) || (r_n == 2'd3);
    assign o_sts.out_free = !r_ovalid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_rdata <= r_mem[r_col];
            r_pix   <= i_opcode ? '0 : i_pix;
        end
        if (i_cmd.load) begin
            r_mem[r_col] <= {r_rdata[(LINES-1)*PW-1:0], r_pix};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < WIN; a++) begin
                for (int b = 0; b < WIN; b++) begin
                    r_win[a][b] <= '0;
                end
            end
        end else if (i_cmd.load) begin
            for (int a = 0; a < WIN; a++) begin
                for (int b = WIN - 1; b > 0; b--) begin
                    r_win[a][b] <= r_win[a][b-1];
                end
                r_win[a][0] <= (a == 0) ? r_pix : r_rdata[(a > 0 ? a - 1 : 0)*PW +: PW];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row    <= '0;
            r_col    <= '0;
            r_any    <= 1'b0;
            r_pv     <= 1'b0;
            r_ovalid <= 1'b0;
            r_dyi    <= '0;
            r_dxi    <= '0;
            r_n      <= '0;
        end else begin
            r_pv <= i_cmd.tap;
            if (i_cmd.load) begin
                r_y      <= y_s[11:0];
                r_x      <= xlo_s[CW-1:0];
                r_xhi    <= rowend ? w_lim[CW-1:0] : lo_s[CW-1:0];
                r_any    <= any;
                r_rowend <= rowend;
                r_wrap   <= (t_s >= hm1_s + rad_s);
                r_n      <= '0;
            end
            if (i_cmd.prep) begin
                r_dyi <= '0;
                r_dxi <= '0;
            end
            if (i_cmd.tap) begin
                if (r_dxi == span) begin
                    r_dxi <= '0;
                    r_dyi <= r_dyi + 3'd1;
                end else begin
                    r_dxi <= r_dxi + 3'd1;
                end
            end
            if (i_cmd.next_x) begin
                r_x <= r_x + CW'(1);
                r_n <= r_n + 2'd1;
            end
            if (i_cmd.emit) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            if (i_cmd.finish) begin
                if (r_rowend) begin
                    r_col <= '0;
                    r_row <= r_wrap ? '0 : r_row + 13'd1;
                end else begin
                    r_col <= r_col + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.tap) begin
            r_tap   <= r_win[a_idx][b_idx];
            r_wprod <= gbr_pkg::f_weight(i_cfg, dy_abs[1:0])
                     * gbr_pkg::f_weight(i_cfg, dx_abs[1:0]);
        end
        if (i_cmd.prep) begin
            for (int k = 0; k < 3; k++) begin
                r_acc[k] <= '0;
            end
        end else if (r_pv) begin
            for (int k = 0; k < 3; k++) begin
                r_acc[k] <= r_acc[k] + AC'(r_wprod) * AC'(r_tap[k*8 +: 8]);
            end
        end
        if (i_cmd.emit) begin
            o_out_pix  <= {gbr_pkg::f_sat(r_acc[2]), gbr_pkg::f_sat(r_acc[1]),
                           gbr_pkg::f_sat(r_acc[0])};
            o_out_last <= o_sts.x_last;
            o_out_eof  <= (r_y == h_m1) && ({{(13-CW){1'b0}}, r_x} == w_lim);
        end
    end

    assign o_out_valid = r_ovalid;

endmodule
`default_nettype wire

@@ hdl/gaussian_blur_rgb_stream.sv @@
// Channel    Direction  Payload
// s_axis     in         tdata {blue, green, red}, tuser drain flag
// m_axis     out        tdata {blue, green, red}, tlast last of run, tuser end of frame
// cfg        in         write enable, register index, data
//
// An item yields from 1 to 4 results, or none at all; a new item is accepted only after the
// controller has finished the current one and returned to idle.
// The single shared tap multiply-accumulate unit takes one window tap per cycle.
// Reset is synchronous and active low; the line store is not cleared.
// A stalled output holds the controller in its emit step until the result is taken.
`default_nettype none
`include "gaussian_blur_rgb_stream_macros.svh"
module gaussian_blur_rgb_stream #(
    parameter int MAX_RADIUS = 3,
    parameter int MAX_WIDTH  = 1024
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    input  wire logic [23:0]                       i_s_axis_tdata,  // blue, green, red
    input  wire logic                              i_s_axis_tuser,  // opcode
    output logic                                   o_m_axis_tvalid,
    input  wire logic                              i_m_axis_tready,
    output logic [23:0]                            o_m_axis_tdata,  // blue, green, red
    output logic                                   o_m_axis_tlast,
    output logic                                   o_m_axis_tuser,  // end of frame
    input  wire logic                              i_cfg_we,
    input  wire logic [gbr_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [gbr_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    gbr_pkg::t_cfg r_cfg;
    gbr_pkg::t_cmd cmd;
    gbr_pkg::t_sts sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_width   <= 11'd640;
            r_cfg.frame_height  <= 13'd480;
            r_cfg.kernel_radius <= 2'd1;
            r_cfg.weight0       <= 9'd116;
            r_cfg.weight1       <= 9'd70;
            r_cfg.weight2       <= 9'd0;
            r_cfg.weight3       <= 9'd0;
        end else if (i_cfg_we) begin
            case (gbr_pkg::t_cfg_idx'(i_cfg_idx))
                gbr_pkg::CFG_FRAME_WIDTH:  r_cfg.frame_width   <= i_cfg_data[10:0];
                gbr_pkg::CFG_FRAME_HEIGHT: r_cfg.frame_height  <= i_cfg_data[12:0];
                gbr_pkg::CFG_KERNEL_RAD:   r_cfg.kernel_radius <= i_cfg_data[1:0];
                gbr_pkg::CFG_WEIGHT0:      r_cfg.weight0       <= i_cfg_data[8:0];
                gbr_pkg::CFG_WEIGHT1:      r_cfg.weight1       <= i_cfg_data[8:0];
                gbr_pkg::CFG_WEIGHT2:      r_cfg.weight2       <= i_cfg_data[8:0];
                gbr_pkg::CFG_WEIGHT3:      r_cfg.weight3       <= i_cfg_data[8:0];
                default: begin
                end
            endcase
        end
    end

    gbr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    gbr_dpath #(
        .MAX_RADIUS (MAX_RADIUS),
        .MAX_WIDTH  (MAX_WIDTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_opcode    (i_s_axis_tuser),
        .i_pix       (i_s_axis_tdata),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out_pix   (o_m_axis_tdata),
        .o_out_last  (o_m_axis_tlast),
        .o_out_eof   (o_m_axis_tuser)
    );

    `GBR_AST_NEXT(a_busy_after_accept, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready)
    `GBR_AST_IMPL(a_eof_is_last, o_m_axis_tvalid && o_m_axis_tuser, o_m_axis_tlast)

endmodule
`default_nettype wire

@@ bench/gaussian_blur_rgb_stream_tb.sv @@
`default_nettype none
module gaussian_blur_rgb_stream_tb;

    localparam int LINE_CNT   = 6;
    localparam int WIN_DIM    = 7;
    localparam int WIDTH_MAX  = 1024;
    localparam int HEIGHT_MAX = 4096;
    localparam int DRAIN_WAIT = 300;
    localparam int CYCLE_LIMIT = 4000000;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
        logic       eof;
    } t_blur_pixel;

    class blur_scoreboard;
        logic [23:0] lines [LINE_CNT][WIDTH_MAX];
        logic [23:0] window [WIN_DIM][WIN_DIM];
        int unsigned row_cnt;
        int unsigned col_cnt;
        int unsigned width_reg, height_reg, radius_reg;
        int unsigned wgt [4];
        t_blur_pixel pending_q [$];
        int errors;

        function new();
            foreach (lines[a, b]) lines[a][b] = '0;
            foreach (window[a, b]) window[a][b] = '0;
            row_cnt = 0;
            col_cnt = 0;
            width_reg = 640;
            height_reg = 480;
            radius_reg = 1;
            wgt[0] = 116;
            wgt[1] = 70;
            wgt[2] = 0;
            wgt[3] = 0;
            errors = 0;
        endfunction

        function void set_reg(gbr_pkg::t_cfg_idx idx, int unsigned val);
            case (idx)
                gbr_pkg::CFG_FRAME_WIDTH:  width_reg = val & 'h7FF;
                gbr_pkg::CFG_FRAME_HEIGHT: height_reg = val & 'h1FFF;
                gbr_pkg::CFG_KERNEL_RAD:   radius_reg = val & 'h3;
                gbr_pkg::CFG_WEIGHT0:      wgt[0] = val & 'h1FF;
                gbr_pkg::CFG_WEIGHT1:      wgt[1] = val & 'h1FF;
                gbr_pkg::CFG_WEIGHT2:      wgt[2] = val & 'h1FF;
                gbr_pkg::CFG_WEIGHT3:      wgt[3] = val & 'h1FF;
                default: ;
            endcase
        endfunction

        function int clampi(int v, int lo, int hi);
            if (v < lo) return lo;
            if (v > hi) return hi;
            return v;
        endfunction

        function logic [7:0] sat8(longint unsigned acc);
            acc = acc >> 16;
            return (acc > 255) ? 8'hFF : acc[7:0];
        endfunction

        function int pending();
            return pending_q.size();
        endfunction

        function void note_pixel(logic drain, logic [7:0] red, logic [7:0] green,
                                 logic [7:0] blue);
            int w, h, r, t, c, y, lo, hi, x, dy, dx, a, b, n;
            logic [23:0] pix, p;
            longint unsigned ar, ag, ab, wt;
            bit rowend;
            t_blur_pixel res;
            t_blur_pixel run [$];
            w = clampi(width_reg, 1, WIDTH_MAX);
            h = clampi(height_reg, 1, HEIGHT_MAX);
            r = radius_reg;
            t = row_cnt;
            c = clampi(col_cnt, 0, WIDTH_MAX - 1);
            pix = drain ? 24'h0 : {red, green, blue};
            for (a = 0; a < WIN_DIM; a++) begin
                for (b = WIN_DIM - 1; b > 0; b--) window[a][b] = window[a][b-1];
                window[a][0] = (a == 0) ? pix : lines[a-1][c];
            end
            for (a = LINE_CNT - 1; a > 0; a--) lines[a][c] = lines[a-1][c];
            lines[0][c] = pix;
            rowend = (c >= w - 1);
            y = t - r;
            n = 0;
            if (y >= 0 && y <= h - 1) begin
                lo = c - r;
                hi = rowend ? w - 1 : lo;
                if (lo < 0) lo = 0;
                for (x = lo; x <= hi && n < 4; x++) begin
                    ar = 0;
                    ag = 0;
                    ab = 0;
                    for (dy = -r; dy <= r; dy++) begin
                        a = clampi(t - clampi(y + dy, 0, h - 1), 0, WIN_DIM - 1);
                        for (dx = -r; dx <= r; dx++) begin
                            wt = longint'(wgt[(dy < 0) ? -dy : dy])
                                * longint'(wgt[(dx < 0) ? -dx : dx]);
                            b = clampi(c - clampi(x + dx, 0, w - 1), 0, WIN_DIM - 1);
                            p = window[a][b];
                            ar += wt * p[23:16];
                            ag += wt * p[15:8];
                            ab += wt * p[7:0];
                        end
                    end
                    res.red = sat8(ar);
                    res.green = sat8(ag);
                    res.blue = sat8(ab);
                    res.last = 1'b0;
                    res.eof = (y == h - 1 && x == w - 1);
                    run.push_back(res);
                    n++;
                end
                if (n > 0) run[n-1].last = 1'b1;
            end
            foreach (run[i]) pending_q.push_back(run[i]);
            if (rowend) begin
                col_cnt = 0;
                if (t >= h - 1 + r) row_cnt = 0;
                else row_cnt = (t + 1) & 'h1FFF;
            end else begin
                col_cnt = c + 1;
            end
        endfunction

        task report(string what, int got, int want);
            $display("mismatch on %s: got %0d, expected %0d", what, got, want);
            errors++;
        endtask

        task check_pixel(logic [23:0] data, logic last, logic eof);
            t_blur_pixel e;
            if (pending_q.size() == 0) begin
                report("unexpected result", data, 0);
            end else begin
                e = pending_q.pop_front();
                if (data[7:0] !== e.red) report("red", data[7:0], e.red);
                if (data[15:8] !== e.green) report("green", data[15:8], e.green);
                if (data[23:16] !== e.blue) report("blue", data[23:16], e.blue);
                if (last !== e.last) report("last of run", last, e.last);
                if (eof !== e.eof) report("end of frame", eof, e.eof);
            end
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [23:0] s_data = '0;
    logic s_user = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [23:0] m_data;
    logic m_last;
    logic m_user;
    logic cfg_we = 1'b0;
    logic [gbr_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
    logic [gbr_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    int send_idle = 0;
    int recv_idle = 0;
    int item_total = 0;
    int cycles = 0;
    blur_scoreboard sb = new();

    gaussian_blur_rgb_stream dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_valid),
        .o_s_axis_tready(s_ready),
        .i_s_axis_tdata(s_data),  // blue, green, red
        .i_s_axis_tuser(s_user),  // opcode
        .o_m_axis_tvalid(m_valid),
        .i_m_axis_tready(m_ready),
        .o_m_axis_tdata(m_data),  // blue, green, red
        .o_m_axis_tlast(m_last),
        .o_m_axis_tuser(m_user),  // end of frame
        .i_cfg_we(cfg_we),
        .i_cfg_idx(cfg_idx),
        .i_cfg_data(cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        m_ready <= ($urandom_range(99) >= recv_idle);
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
        if (i_rst_n) begin
            if (m_valid && m_ready) sb.check_pixel(m_data, m_last, m_user);
            if (s_valid && s_ready)
                sb.note_pixel(s_user, s_data[7:0], s_data[15:8], s_data[23:16]);
        end
    end

    task write_reg(gbr_pkg::t_cfg_idx idx, int unsigned val);
        cfg_we = 1'b1;
        cfg_idx = idx;
        cfg_data = val[gbr_pkg::CFG_DATA_W-1:0];
        sb.set_reg(idx, val);
        @(negedge i_clk);
        cfg_we = 1'b0;
    endtask

    task wait_idle();
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task setup_frame(int w, int h, int r, int w0, int w1, int w2, int w3);
        wait_idle();
        write_reg(gbr_pkg::CFG_FRAME_WIDTH, w);
        write_reg(gbr_pkg::CFG_FRAME_HEIGHT, h);
        write_reg(gbr_pkg::CFG_KERNEL_RAD, r);
        write_reg(gbr_pkg::CFG_WEIGHT0, w0);
        write_reg(gbr_pkg::CFG_WEIGHT1, w1);
        write_reg(gbr_pkg::CFG_WEIGHT2, w2);
        write_reg(gbr_pkg::CFG_WEIGHT3, w3);
    endtask

    function logic [7:0] pick_channel();
        case ($urandom_range(3))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task send_item(logic drain);
        if ($urandom_range(99) < send_idle) begin
            s_valid = 1'b0;
            while ($urandom_range(99) < send_idle) @(negedge i_clk);
            @(negedge i_clk);
        end
        s_valid = 1'b1;
        s_user = drain;
        s_data = {pick_channel(), pick_channel(), pick_channel()};
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
        @(negedge i_clk);
        item_total++;
    endtask

    task send_frame(int w, int h, int r, int noise);
        int we, he;
        logic drain;
        we = (w < 1) ? 1 : (w > WIDTH_MAX) ? WIDTH_MAX : w;
        he = (h < 1) ? 1 : h;
        for (int i = 0; i < (he + r) * we; i++) begin
            drain = (i >= he * we);
            if ($urandom_range(99) < noise) drain = ~drain;
            send_item(drain);
        end
        s_valid = 1'b0;
    endtask

    task random_frames(int goal);
        int w, h, r, ws [4];
        while (item_total < goal) begin
            w = $urandom_range(1, 8);
            h = $urandom_range(1, 5);
            r = $urandom_range(0, 3);
            foreach (ws[i]) ws[i] = ($urandom_range(9) == 0) ? $urandom_range(511)
                                                              : $urandom_range(256);
            setup_frame(w, h, r, ws[0], ws[1], ws[2], ws[3]);
            send_frame(w, h, r, ($urandom_range(3) == 0) ? 10 : 0);
        end
    endtask

    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        send_idle = 14;
        recv_idle = 59;
        setup_frame(3, 2, 1, 116, 70, 0, 0);
        send_frame(3, 2, 1, 0);
        setup_frame(0, 0, 3, 511, 511, 511, 511);
        send_frame(0, 0, 3, 0);
        setup_frame(2, 1, 0, 256, 0, 0, 0);
        send_frame(2, 1, 0, 0);
        setup_frame(2, 2, 2, 0, 256, 256, 0);
        send_frame(2, 2, 2, 0);
        random_frames(110);
        send_idle = 59;
        recv_idle = 14;
        random_frames(190);
        send_idle = 0;
        recv_idle = 0;
        random_frames(250);
        setup_frame(2047, 1, 0, 256, 0, 0, 0);
        for (int i = 0; i < 100; i++) begin
            send_item(1'b0);
        end
        s_valid = 1'b0;
        wait_idle();
        if (sb.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
